FILE: hdl/mdts_pkg.sv
package mdts_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int POS_W          = 3;
  localparam int DIGIT_W        = 4;
  localparam int CATHODE_W      = 10;
  localparam int ANODE_W        = 4;

  // op codes
  localparam logic [2:0] OP_SCAN   = 3'd0;
  localparam logic [2:0] OP_CHAR   = 3'd1;
  localparam logic [2:0] OP_DOT    = 3'd2;
  localparam logic [2:0] OP_NUMBER = 3'd3;
  localparam logic [2:0] OP_BLANK  = 3'd4;

  localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd15;
  localparam logic [7:0]         CHAR_ZERO  = 8'h30;
  localparam logic [7:0]         CHAR_NINE  = 8'h39;

  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic [2:0]       op;
    logic [POS_W-1:0] position;
    logic [7:0]       char_code;
    logic             dot_on;
    logic [31:0]      number;
  } cmd_t;

  typedef struct packed {
    logic [CATHODE_W-1:0] cathode_lines;
    logic                 dot_line;
    logic [ANODE_W-1:0]   anode_lines;
  } disp_t;

endpackage

FILE: hdl/multiplexed_decimal_tube_scanner.sv
// Scan driver for a multiplexed decimal-tube display of NUM_DIGITS positions.
// Command channel (cmd_valid / cmd_stall / cmd): one transfer per command,
// which is a scan tick, a char write, a dot write, a number write or a
// blank-all. Display channel (disp_valid / disp_stall / disp): exactly one
// transfer per command, carrying the line drive after that command.
// Scan tick, char, dot and blank-all commands show their result in the
// cycle after the transfer, so with a receiver that never stalls one
// such command goes through every cycle. A number write runs the shared
// divide-by-ten unit once per position, each digit as a reciprocal
// multiply (ST_MUL), then a remainder and store (ST_DIGIT), so its result
// appears once the last digit is stored; cmd_stall stays high meanwhile.
// While disp is held by disp_stall, cmd_stall is high: the drive does not
// move until the pending result has been taken.
// Reset (rst, synchronous): active position 0, all digits numeral 0, all
// dots off, all lines off, no result pending. All state is in flip-flops,
// so no clearing pass follows reset.
module multiplexed_decimal_tube_scanner
  import mdts_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_stall,
  input  cmd_t  cmd,
  output logic  disp_valid,
  input  logic  disp_stall,
  output disp_t disp
);

  localparam int PW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(NUM_DIGITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MUL   = 3'b010,
    ST_DIGIT = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [PW-1:0]       active_position;
  logic [DIGIT_W-1:0]  digit_store [NUM_DIGITS];
  logic                dot_store   [NUM_DIGITS];
  logic [PW-1:0]       dig;
  logic [31:0]         num;
  logic [63:0]         prod;

  logic                accept;
  logic                pos_ok;
  logic [PW-1:0]       wpos;
  logic [PW-1:0]       scan_pos;
  logic [DIGIT_W-1:0]  scan_digit;
  logic                scan_dot;
  logic                scan_lit;
  logic [POS_W-1:0]    scan_pos_ext;
  disp_t               scan_drive;
  logic [28:0]         quot;
  logic [31:0]         quot_ten;
  logic [DIGIT_W-1:0]  rem;
  logic                last_digit;

  // Hold off new commands while dividing or while a result waits.
  assign cmd_stall = (state != ST_IDLE) || (disp_valid && disp_stall);
  assign accept    = cmd_valid && !cmd_stall;

  assign pos_ok = {1'b0, cmd.position} < (POS_W + 1)'(NUM_DIGITS);
  assign wpos   = cmd.position[PW-1:0];

  // Next scan position and its drive.
  always_comb begin
    scan_pos     = (active_position == LAST_POS) ? '0 : active_position + 1'b1;
    scan_digit   = digit_store[scan_pos];
    scan_dot     = dot_store[scan_pos];
    scan_pos_ext = POS_W'(scan_pos);
    scan_drive   = '0;
    if (scan_digit <= 4'd9) begin
      scan_drive.cathode_lines = CATHODE_W'(1) << scan_digit;
    end
    scan_drive.dot_line = scan_dot;
    scan_lit = (scan_digit <= 4'd9) || scan_dot;
    // Positions past the anode field have no line and stay dark.
    for (int k = 0; k < ANODE_W; k++) begin
      scan_drive.anode_lines[k] = scan_lit && (scan_pos_ext == POS_W'(k));
    end
  end

  // Remainder step of the divide-by-ten unit.
  assign quot       = prod[63:RECIP_SHIFT];
  assign quot_ten   = {quot[28:0], 3'b000} + {2'b00, quot[28:0], 1'b0};
  assign rem        = DIGIT_W'(num - quot_ten);
  assign last_digit = (dig == LAST_POS);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd.op == OP_NUMBER) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        state_next = last_digit ? ST_IDLE : ST_MUL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      active_position <= '0;
      disp_valid      <= 1'b0;
      disp            <= '0;
      dig             <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_store[i] <= '0;
        dot_store[i]   <= 1'b0;
      end
    end else begin
      state <= state_next;

      if (accept) begin
        case (cmd.op)
          OP_SCAN: begin
            active_position <= scan_pos;
            disp            <= scan_drive;
          end
          OP_CHAR: begin
            if (pos_ok) begin
              if (cmd.char_code >= CHAR_ZERO && cmd.char_code <= CHAR_NINE) begin
                digit_store[wpos] <= DIGIT_W'(cmd.char_code - CHAR_ZERO);
              end else begin
                digit_store[wpos] <= BLANK_CODE;
              end
              dot_store[wpos] <= cmd.dot_on;
            end
          end
          OP_DOT: begin
            if (pos_ok) begin
              dot_store[wpos] <= cmd.dot_on;
            end
          end
          OP_NUMBER: begin
            num <= cmd.number;
            dig <= '0;
          end
          OP_BLANK: begin
            disp <= '0;
          end
          default: begin
          end
        endcase
      end

      case (state)
        ST_MUL: begin
          prod <= num * RECIP_TEN;
        end
        ST_DIGIT: begin
          // Blank leading zeros, but always show the lowest position.
          digit_store[dig] <= (dig == '0 || num != '0) ? rem : BLANK_CODE;
          num <= {3'b000, quot};
          if (!last_digit) begin
            dig <= dig + 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Raise the result for a finished command; a number write reports
      // once its digits are stored. Drop the result once taken.
      if ((accept && cmd.op != OP_NUMBER) || (state == ST_DIGIT && last_digit)) begin
        disp_valid <= 1'b1;
      end else if (disp_valid && !disp_stall) begin
        disp_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_number_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.op == OP_NUMBER) |=> (state == ST_MUL))
    else $error("number write did not start the divide sequence");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !disp_valid)
    else $error("result pending during number write");

  a_drive_only_on_transfer: assert property (@(posedge clk) disable iff (rst)
    (!accept && !rst) |=> $stable(disp))
    else $error("line drive changed without a command transfer");

  a_anode_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(disp.anode_lines) && $onehot0(disp.cathode_lines))
    else $error("anode or cathode drive not one-hot");

  a_anode_needs_light: assert property (@(posedge clk) disable iff (rst)
    (disp.anode_lines != '0) |-> (disp.cathode_lines != '0 || disp.dot_line))
    else $error("anode enabled on a dark position");
`endif

endmodule
